@@ design/sha512_pkg.sv @@
// Package with SHA-512 constants, round functions and sequencer codes.
package sha512_pkg;

   localparam int WordWidth = 64;
   localparam int NumRounds = 80;

   localparam logic [63:0] ROUND_K [NumRounds] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   localparam logic [63:0] INIT_HASH [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   // Sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_PAD   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   typedef logic [63:0] word_type;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (64 - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic word_type sig1(input word_type x);
      sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

   function automatic word_type big0(input word_type x);
      big0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic word_type big1(input word_type x);
      big1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

endpackage

@@ design/sha512_message_hash.sv @@
// SHA-512 hash engine: word buffering, padding, one round per cycle, digest output.
//
// Input channel req_*: one 64-bit big-endian message word per transaction,
// with req_valid_bytes (0..8 leading bytes valid, below 8 only with
// req_last_item) and req_last_item marking the final word of the message.
// The block raises req_stall while it compresses, pads or emits.
// Output channel rsp_*: after a last word, eight transactions carry the
// digest words 0..7; rsp_last_word marks word 7.
// Sequence: the sixteenth word of a block starts the compression: 80 rounds
// through the one shared round unit, then an add into the hash words.
// A last word adds one or two padding blocks (each filled, then compressed)
// and then the digest output, one digest word per cycle while rsp_stall is low.
// When the receiver stalls, the current digest word holds on rsp_* and the
// block waits; no input is taken until all eight words are delivered.
// Reset (synchronous, active high) loads the initial hash values and
// clears counters; the block buffer needs no clearing.
module sha512_message_hash (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [63:0]           req_message_word,
   input  logic [3:0]            req_valid_bytes,
   input  logic                  req_last_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [63:0]           rsp_digest_word,
   output logic [2:0]            rsp_digest_index,
   output logic                  rsp_last_word
);
   import sha512_pkg::*;

   logic [2:0]  state_ff, state_in;
   word_type    hash_ff [8];
   word_type    var_ff [8];
   word_type    sched_ff [16];
   logic [63:0] count_ff, count_in;
   logic [3:0]  pos_ff;
   logic [6:0]  round_ff;
   logic        padlen_ff;   // length word still owed
   logic        finish_ff;   // message ended, digest follows this block
   logic [2:0]  out_idx_ff;
   logic        pad80_ff;    // 0x80 word still owed after a full last word
   logic        short_ff;    // pad word took slot 14, length goes in the next block

   logic        accept;
   logic [3:0]  vb;
   word_type    keep, padw, wt, t1, t2, w_new, push_w;
   logic        push;
   logic        pad_push;
   logic [3:0]  pos_in;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign vb        = (!req_last_item || req_valid_bytes > 4'd8) ? 4'd8 : req_valid_bytes;
   assign count_in  = count_ff + 64'(vb);

   // Build the padded word for a partial last word
   always_comb begin
      keep = (vb == 4'd0) ? '0 : ~(64'hffffffffffffffff >> (8 * vb));
      padw = (req_message_word & keep) | (64'h80 << (56 - 8 * vb));
   end

   // Shared round unit; schedule kept as a 16-word sliding window
   always_comb begin
      wt    = sched_ff[0];
      w_new = sig1(sched_ff[14]) + sched_ff[9] + sig0(sched_ff[1]) + sched_ff[0];
      t1    = var_ff[7] + big1(var_ff[4]) + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]))
              + ROUND_K[round_ff] + wt;
      t2    = big0(var_ff[0]) + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2])
              ^ (var_ff[1] & var_ff[2]));
   end

   // Pick the word to push into the block buffer in idle or padding
   always_comb begin
      push     = 1'b0;
      push_w   = '0;
      pad_push = 1'b0;
      if (state_ff == ST_IDLE && accept) begin
         push     = 1'b1;
         pad_push = req_last_item && vb != 4'd8;
         push_w   = (req_last_item && vb != 4'd8) ? padw : req_message_word;
      end else if (state_ff == ST_PAD) begin
         push     = 1'b1;
         pad_push = pad80_ff;
         if (pad80_ff) begin
            push_w = 64'h8000000000000000;
         end else if (pos_ff == 4'd15 && padlen_ff && !short_ff) begin
            push_w = {count_ff[60:0], 3'b000};
         end else begin
            push_w = '0;
         end
      end
      pos_in = pos_ff + 4'd1;
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (pos_ff == 4'd15) state_in = ST_ROUND;
               else if (req_last_item) state_in = ST_PAD;
            end
         end
         ST_ROUND: if (round_ff == 7'(NumRounds - 1)) state_in = ST_ADD;
         ST_ADD: begin
            if (finish_ff) state_in = ST_OUT;
            else if (padlen_ff) state_in = ST_PAD;
            else state_in = ST_IDLE;
         end
         ST_PAD: if (pos_ff == 4'd15) state_in = ST_ROUND;
         ST_OUT: if (!rsp_stall && out_idx_ff == 3'd7) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         pos_ff     <= '0;
         round_ff   <= '0;
         padlen_ff  <= 1'b0;
         finish_ff  <= 1'b0;
         out_idx_ff <= '0;
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= INIT_HASH[i];
            var_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         // Take a message word
         if (state_ff == ST_IDLE && accept) begin
            count_ff <= count_in;
            if (req_last_item) begin
               padlen_ff <= 1'b1;
               // a full last word still needs the 0x80 word pushed
               if (vb == 4'd8) finish_ff <= 1'b0;
            end
         end
         // Fill the buffer slot
         if (push) begin
            sched_ff[pos_ff] <= push_w;
            pos_ff           <= pos_in;
            if (state_ff == ST_PAD && pos_ff == 4'd15 && padlen_ff && !pad80_ff
                && !short_ff) begin
               padlen_ff <= 1'b0;
               finish_ff <= 1'b1;
            end
            if (pos_ff == 4'd15) begin
               for (int i = 0; i < 8; i++) var_ff[i] <= hash_ff[i];
               round_ff <= '0;
            end
         end
         // Run one round and slide the schedule
         if (state_ff == ST_ROUND) begin
            var_ff[7] <= var_ff[6];
            var_ff[6] <= var_ff[5];
            var_ff[5] <= var_ff[4];
            var_ff[4] <= var_ff[3] + t1;
            var_ff[3] <= var_ff[2];
            var_ff[2] <= var_ff[1];
            var_ff[1] <= var_ff[0];
            var_ff[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) sched_ff[i] <= sched_ff[i + 1];
            sched_ff[15] <= w_new;
            round_ff <= round_ff + 7'd1;
         end
         // Fold the block into the hash
         if (state_ff == ST_ADD) begin
            for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + var_ff[i];
            round_ff   <= '0;
            out_idx_ff <= '0;
         end
         // Emit digest words, then restore for the next message
         if (state_ff == ST_OUT && !rsp_stall) begin
            out_idx_ff <= out_idx_ff + 3'd1;
            if (out_idx_ff == 3'd7) begin
               for (int i = 0; i < 8; i++) hash_ff[i] <= INIT_HASH[i];
               count_ff  <= '0;
               pos_ff    <= '0;
               finish_ff <= 1'b0;
               padlen_ff <= 1'b0;
            end
         end
      end
   end

   // The padding run: a full last word gets the 0x80 word first
   always_ff @(posedge clock) begin
      if (reset) begin
         pad80_ff <= 1'b0;
      end else if (state_ff == ST_IDLE && accept) begin
         pad80_ff <= req_last_item && (vb == 4'd8);
      end else if (state_ff == ST_PAD && pad80_ff) begin
         pad80_ff <= 1'b0;
      end
   end

   // Hold the length back one block when the pad word lands in slot 14
   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff <= 1'b0;
      end else if (push) begin
         if (pad_push) short_ff <= (pos_ff == 4'd14);
         else if (pos_ff == 4'd15) short_ff <= 1'b0;
      end
   end

   assign rsp_valid        = (state_ff == ST_OUT) && !pad80_ff;
   assign rsp_digest_word  = hash_ff[out_idx_ff];
   assign rsp_digest_index = out_idx_ff;
   assign rsp_last_word    = (out_idx_ff == 3'd7);

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the SHA-512 message hash engine.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sha512_pkg::*;

   localparam int StallLimit = 20000;
   localparam int HoldOffCycles = 400;

   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        last;
   } msg_item_type;

   typedef struct packed {
      logic [63:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_item_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_message_word;
   logic [3:0]  req_valid_bytes;
   logic        req_last_item;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_digest_word;
   logic [2:0]  rsp_digest_index;
   logic        rsp_last_word;

   msg_item_type    pending_words[$];
   digest_item_type expected_digest[$];
   int           error_count;
   int           idle_cycles;
   int           hold_left;
   bit           quiet_phase;
   bit           hold_off_req;
   bit           req_fire;

   // running hash state of the predictor
   logic [63:0] hash_state[8];
   logic [63:0] block_words[16];
   logic [63:0] byte_total;
   int          fill_pos;

   sha512_message_hash uut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] ror(input logic [63:0] x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   // run the 80-round compression on the buffered block
   task automatic compress_block_words();
      logic [63:0] w[80];
      logic [63:0] v[8];
      logic [63:0] t1, t2, s0, s1;
      for (int t = 0; t < 16; t++) w[t] = block_words[t];
      for (int t = 16; t < 80; t++) begin
         s0 = ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7);
         s1 = ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6);
         w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int r = 0; r < 80; r++) begin
         t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
         t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   task automatic append_block_word(input logic [63:0] w);
      block_words[fill_pos] = w;
      fill_pos = (fill_pos + 1) % 16;
      if (fill_pos == 0) compress_block_words();
   endtask

   // fold one accepted message word into the hash, queue digest on last
   task automatic absorb_message_word(input msg_item_type m);
      int          n;
      logic [63:0] pad_word;
      logic [63:0] keep;
      digest_item_type d;
      n = (!m.last || m.nbytes > 8) ? 8 : int'(m.nbytes);
      byte_total += 64'(n);
      if (!m.last) begin
         append_block_word(m.word);
         return;
      end
      if (n == 8) begin
         append_block_word(m.word);
         pad_word = 64'h8000_0000_0000_0000;
      end else begin
         keep = (n == 0) ? 64'd0 : ~64'd0 << (64 - 8 * n);
         pad_word = (m.word & keep) | (64'h80 << (56 - 8 * n));
      end
      append_block_word(pad_word);
      if (fill_pos == 15) append_block_word(64'd0);
      while (fill_pos != 14) append_block_word(64'd0);
      append_block_word(64'd0);
      append_block_word(byte_total << 3);
      for (int i = 0; i < 8; i++) begin
         d.word  = hash_state[i];
         d.index = 3'(i);
         d.last  = (i == 7);
         expected_digest.push_back(d);
      end
      for (int i = 0; i < 8; i++) hash_state[i] = INIT_HASH[i];
      byte_total = 64'd0;
      fill_pos = 0;
   endtask

   function automatic bit take_gap();
      return !quiet_phase && ($urandom_range(99) < 19);
   endfunction

   task automatic add_word(input logic [63:0] w, input int nb, input bit last);
      msg_item_type m;
      m.word = w;
      m.nbytes = 4'(nb);
      m.last = last;
      pending_words.push_back(m);
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic add_random_message(input int len, input int tail_bytes);
      for (int i = 0; i < len; i++) add_word(rand_word(), $urandom_range(15), 1'b0);
      add_word(rand_word(), tail_bytes, 1'b1);
   endtask

   // record whether the input transaction was taken at this rising edge
   always @(posedge clock) begin
      req_fire <= req_valid && !req_stall;
   end

   // driver: present the head of the pending queue at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_valid) void'(pending_words.pop_front());
         if (pending_words.size() > 0 && !take_gap()) begin
            req_valid        <= 1'b1;
            req_message_word <= pending_words[0].word;
            req_valid_bytes  <= pending_words[0].nbytes;
            req_last_item    <= pending_words[0].last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with one long counted hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= HoldOffCycles;
      end else if (hold_off_req && hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= take_gap();
      end
   end

   // monitor: predict on accepted words, check accepted digest words
   always @(posedge clock) begin
      digest_item_type e;
      if (!reset) begin
         if (req_valid && !req_stall) absorb_message_word({req_message_word,
                                                           req_valid_bytes, req_last_item});
         if (rsp_valid && !rsp_stall) begin
            if (expected_digest.size() == 0) begin
               $display("%0t: unexpected digest word %h", $time, rsp_digest_word);
               error_count++;
            end else begin
               e = expected_digest.pop_front();
               if (rsp_digest_word !== e.word || rsp_digest_index !== e.index
                   || rsp_last_word !== e.last) begin
                  $display("%0t: digest mismatch expected %h/%0d/%b actual %h/%0d/%b",
                           $time, e.word, e.index, e.last,
                           rsp_digest_word, rsp_digest_index, rsp_last_word);
                  error_count++;
               end
            end
         end
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int len;
      error_count = 0;
      quiet_phase = 0;
      hold_off_req = 0;
      for (int i = 0; i < 8; i++) hash_state[i] = INIT_HASH[i];
      byte_total = 64'd0;
      fill_pos = 0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: empty message, "abc", several tail sizes, over-size counts, block edges
      add_word(64'd0, 0, 1'b1);
      add_word(64'h6162_6300_0000_0000, 3, 1'b1);
      add_word(64'hffff_ffff_ffff_ffff, 8, 1'b1);
      add_word(64'hffff_ffff_ffff_ffff, 15, 1'b1);
      add_word(64'hffff_ffff_ffff_ffff, 3, 1'b0);
      add_word(64'hffff_ffff_ffff_ffff, 7, 1'b1);
      add_word(64'h0123_4567_89ab_cdef, 1, 1'b1);
      add_random_message(13, 8);
      add_random_message(14, 0);
      add_random_message(15, 0);

      // random messages
      while (pending_words.size() < 320) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(16);
         add_random_message(len, $urandom_range(15));
      end

      // long idle-free stretch in the middle of the run
      wait (pending_words.size() < 230);
      quiet_phase = 1;
      wait (pending_words.size() < 150);
      quiet_phase = 0;

      // hold off the receiver while more messages keep coming
      wait (pending_words.size() < 100);
      hold_off_req = 1;

      wait (pending_words.size() == 0 && !req_valid);
      wait (expected_digest.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_digest.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
